/* sv/tcpq_pkg.sv */
// Package for the two-class priority queue: sizes, status codes, controller
// states and the command and status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_WIDTH = 32;

  localparam int IN_ID_W  = 32;
  localparam int OCC_W    = 5;
  localparam int STORE_W  = (ID_WIDTH < IN_ID_W) ? ID_WIDTH : IN_ID_W;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic take;
    logic load_id;
  } cmd_t;

  typedef struct packed {
    logic needs_read;
    cnt_t total;
  } stat_t;

  function automatic ptr_t next_ptr(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(CAPACITY - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

/* sv/tcpq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tcpq_datapath.sv */
// Datapath of the two-class priority queue: per-class pointers and counts,
// the two entry RAMs and the result register. Depends on tcpq_pkg, tcpq_ram.
`timescale 1ns / 1ps

module tcpq_datapath import tcpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               action,
  input  logic [IN_ID_W-1:0] item_id,
  input  logic               preferred,
  output logic [1:0]         status,
  output logic [IN_ID_W-1:0] out_id,
  output logic               out_preferred,
  output logic [OCC_W-1:0]   occupancy
);

  ptr_t pref_head, pref_tail, reg_head, reg_tail;
  ptr_t pref_head_next, pref_tail_next, reg_head_next, reg_tail_next;
  cnt_t pref_count, reg_count;
  cnt_t pref_count_next, reg_count_next;
  cnt_t total, total_next;
  logic full;
  logic pref_we, reg_we;
  logic [STORE_W-1:0] wdata;
  logic [STORE_W-1:0] pref_rdata, reg_rdata;
  logic sel_pref, sel_pref_next;
  status_t status_r, status_next;
  logic [IN_ID_W-1:0] id_r;
  logic pref_r, pref_next;
  logic [OCC_W-1:0] occ_r;

  assign total = pref_count + reg_count;
  assign full  = (total == cnt_t'(CAPACITY));
  assign wdata = STORE_W'(item_id);

  always_comb begin
    pref_head_next  = pref_head;
    pref_tail_next  = pref_tail;
    reg_head_next   = reg_head;
    reg_tail_next   = reg_tail;
    pref_count_next = pref_count;
    reg_count_next  = reg_count;
    total_next      = total;
    pref_we         = 1'b0;
    reg_we          = 1'b0;
    sel_pref_next   = 1'b0;
    pref_next       = 1'b0;
    status_next     = ST_EMPTY;
    if (action == ACT_ENQUEUE) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_ENQUEUED;
        total_next  = total + cnt_t'(1);
        if (preferred) begin
          pref_we         = 1'b1;
          pref_tail_next  = next_ptr(pref_tail);
          pref_count_next = pref_count + cnt_t'(1);
        end else begin
          reg_we         = 1'b1;
          reg_tail_next  = next_ptr(reg_tail);
          reg_count_next = reg_count + cnt_t'(1);
        end
      end
    end else begin
      if (pref_count != '0) begin
        status_next     = ST_DEQUEUED;
        sel_pref_next   = 1'b1;
        pref_next       = 1'b1;
        total_next      = total - cnt_t'(1);
        pref_head_next  = next_ptr(pref_head);
        pref_count_next = pref_count - cnt_t'(1);
      end else if (reg_count != '0) begin
        status_next    = ST_DEQUEUED;
        total_next     = total - cnt_t'(1);
        reg_head_next  = next_ptr(reg_head);
        reg_count_next = reg_count - cnt_t'(1);
      end
    end
  end

  assign stat.needs_read = (action == ACT_DEQUEUE) && (total != '0);
  assign stat.total      = total;

  tcpq_ram #(.WIDTH(STORE_W), .DEPTH(CAPACITY)) u_pref_ram (
    .clk   (clk),
    .we    (cmd.take && pref_we),
    .waddr (pref_tail),
    .wdata (wdata),
    .raddr (pref_head),
    .rdata (pref_rdata)
  );

  tcpq_ram #(.WIDTH(STORE_W), .DEPTH(CAPACITY)) u_reg_ram (
    .clk   (clk),
    .we    (cmd.take && reg_we),
    .waddr (reg_tail),
    .wdata (wdata),
    .raddr (reg_head),
    .rdata (reg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pref_head  <= '0;
      pref_tail  <= '0;
      reg_head   <= '0;
      reg_tail   <= '0;
      pref_count <= '0;
      reg_count  <= '0;
    end else if (cmd.take) begin
      pref_head  <= pref_head_next;
      pref_tail  <= pref_tail_next;
      reg_head   <= reg_head_next;
      reg_tail   <= reg_tail_next;
      pref_count <= pref_count_next;
      reg_count  <= reg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      status_r <= status_next;
      id_r     <= '0;
      pref_r   <= pref_next;
      occ_r    <= OCC_W'(total_next);
      sel_pref <= sel_pref_next;
    end else if (cmd.load_id) begin
      id_r <= sel_pref ? IN_ID_W'(pref_rdata) : IN_ID_W'(reg_rdata);
    end
  end

  assign status        = status_r;
  assign out_id        = id_r;
  assign out_preferred = pref_r;
  assign occupancy     = occ_r;

endmodule

/* sv/tcpq_ctrl.sv */
// Controller of the two-class priority queue: input and output handshakes
// and the wait for the registered RAM read on a dequeue. Depends on tcpq_pkg.
`timescale 1ns / 1ps

module tcpq_ctrl import tcpq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   valid_r, valid_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take && stat.needs_read) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.take    = 1'b0;
    cmd.load_id = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !valid_r || out_ready;
        cmd.take = in_valid && in_ready;
      end
      S_READ: begin
        cmd.load_id = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_next = valid_r && !out_ready;
    if ((cmd.take && !stat.needs_read) || cmd.load_id) begin
      valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state   <= state_next;
      valid_r <= valid_next;
    end
  end

  assign out_valid = valid_r;

endmodule

/* sv/two_class_priority_queue.sv */
// Top level of the two-class strict-priority queue.
// Depends on tcpq_pkg, tcpq_ctrl, tcpq_datapath (and through it tcpq_ram).
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   action, item_id, preferred
//   output   out_valid / out_ready status, out_id, out_preferred, occupancy
//
// Enqueues and failed dequeues have their result registered when the input is accepted.
// A successful dequeue also passes through S_READ, as the entry RAMs register the read.
// In_ready is low during the read cycle of a dequeue.
// A result waiting for out_ready holds off input; a new transfer enters as it leaves.
// Reset clears pointers, counts and handshake state; RAM contents are untouched.
`timescale 1ns / 1ps

module two_class_priority_queue import tcpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [IN_ID_W-1:0] item_id,
  input  logic               preferred,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [IN_ID_W-1:0] out_id,
  output logic               out_preferred,
  output logic [OCC_W-1:0]   occupancy
);

  cmd_t  cmd;
  stat_t stat;

  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcpq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .item_id       (item_id),
    .preferred     (preferred),
    .status        (status),
    .out_id        (out_id),
    .out_preferred (out_preferred),
    .occupancy     (occupancy)
  );

  a_enq_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_ENQUEUE) |=>
      (out_valid && (status == ST_ENQUEUED || status == ST_FULL)))
    else $error("enqueue did not produce a result in the next cycle");

  a_no_id_unless_deq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DEQUEUED) |-> (out_id == '0 && !out_preferred))
    else $error("entry fields set on a result that removed nothing");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    stat.total <= cnt_t'(CAPACITY))
    else $error("total occupancy exceeds capacity");

  a_read_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.load_id |-> !in_ready)
    else $error("input taken while a dequeue read is pending");

endmodule

/* dv/two_class_priority_queue_tb.sv */
// Self-checking testbench for two_class_priority_queue, built on tcpq_pkg.
// A directed table is followed by random traffic in enqueue-heavy, balanced and dequeue-heavy
// bursts; each result is checked against its table row or a behavioral copy of the queue.
`timescale 1ns / 1ps

module two_class_priority_queue_tb;
  import tcpq_pkg::*;

  typedef struct {
    status_t            st;
    logic [IN_ID_W-1:0] id;
    logic               pref;
    logic [OCC_W-1:0]   occ;
  } queue_result_t;

  typedef struct {
    action_t            act;
    logic [IN_ID_W-1:0] id;
    logic               pref;
    bit                 typed;
    queue_result_t      want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = 1'b0;
  logic [IN_ID_W-1:0] item_id = '0;
  logic               preferred = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [IN_ID_W-1:0] out_id;
  logic               out_preferred;
  logic [OCC_W-1:0]   occupancy;

  logic [STORE_W-1:0] pref_ids [CAPACITY];
  logic [STORE_W-1:0] reg_ids  [CAPACITY];
  ptr_t               pref_rd = '0;
  ptr_t               pref_wr = '0;
  ptr_t               reg_rd  = '0;
  ptr_t               reg_wr  = '0;
  cnt_t               pref_held = '0;
  cnt_t               reg_held  = '0;

  queue_result_t      awaited_results [$];
  int                 mismatch_count = 0;
  bit                 quiet = 1'b0;

  two_class_priority_queue i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .item_id       (item_id),
    .preferred     (preferred),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_id        (out_id),
    .out_preferred (out_preferred),
    .occupancy     (occupancy)
  );

  always #10 clk = ~clk;

  function automatic ptr_t wrap_inc(input ptr_t p);
    return (int'(p) == CAPACITY - 1) ? ptr_t'(0) : ptr_t'(p + 1'b1);
  endfunction

  function automatic queue_result_t strict_priority_step(input action_t act,
      input logic [IN_ID_W-1:0] id, input logic pref);
    queue_result_t r;
    r.st   = ST_ENQUEUED;
    r.id   = '0;
    r.pref = 1'b0;
    if (act == ACT_ENQUEUE) begin
      if (int'(pref_held) + int'(reg_held) >= CAPACITY) begin
        r.st = ST_FULL;
      end else if (pref) begin
        pref_ids[pref_wr] = id[STORE_W-1:0];
        pref_wr = wrap_inc(pref_wr);
        pref_held++;
      end else begin
        reg_ids[reg_wr] = id[STORE_W-1:0];
        reg_wr = wrap_inc(reg_wr);
        reg_held++;
      end
    end else if (pref_held != 0) begin
      r.st   = ST_DEQUEUED;
      r.id   = IN_ID_W'(pref_ids[pref_rd]);
      r.pref = 1'b1;
      pref_rd = wrap_inc(pref_rd);
      pref_held--;
    end else if (reg_held != 0) begin
      r.st = ST_DEQUEUED;
      r.id = IN_ID_W'(reg_ids[reg_rd]);
      reg_rd = wrap_inc(reg_rd);
      reg_held--;
    end else begin
      r.st = ST_EMPTY;
    end
    r.occ = OCC_W'(int'(pref_held) + int'(reg_held));
    return r;
  endfunction

  function automatic stim_row_t make_row(input action_t act, input logic [IN_ID_W-1:0] id,
      input logic pref, input bit typed, input status_t st, input logic [IN_ID_W-1:0] oid,
      input logic opref, input int occ);
    stim_row_t row;
    row.act       = act;
    row.id        = id;
    row.pref      = pref;
    row.typed     = typed;
    row.want.st   = st;
    row.want.id   = oid;
    row.want.pref = opref;
    row.want.occ  = OCC_W'(occ);
    return row;
  endfunction

  function automatic int pause_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(6, 25);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // The transfer is decided at the falling edge and takes place at the next rising edge.
  task automatic send_item(input stim_row_t row);
    int            gap;
    queue_result_t r;
    gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= row.act;
    item_id   <= row.id;
    preferred <= row.pref;
    do begin
      @(negedge clk);
    end while (in_ready !== 1'b1);
    r = strict_priority_step(row.act, row.id, row.pref);
    awaited_results.push_back(row.typed ? row.want : r);
    @(posedge clk);
  endtask

  initial begin : result_sink
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet) begin
        out_ready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin : result_check
    queue_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing awaited: status %0d id %h",
                                status, out_id));
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.st) begin
          flag_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        end
        if (out_id !== want.id) begin
          flag_mismatch($sformatf("out_id %h, expected %h", out_id, want.id));
        end
        if (out_preferred !== want.pref) begin
          flag_mismatch($sformatf("out_preferred %b, expected %b", out_preferred, want.pref));
        end
        if (occupancy !== want.occ) begin
          flag_mismatch($sformatf("occupancy %0d, expected %0d", occupancy, want.occ));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t          rows [$];
    stim_row_t          row;
    int                 seg_left;
    int                 enq_pct;
    logic [IN_ID_W-1:0] id;
    seg_left = 0;
    enq_pct  = 50;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(make_row(ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_EMPTY, '0, 1'b0, 0));
    rows.push_back(make_row(ACT_ENQUEUE, 32'h0000_0000, 1'b0, 1'b1, ST_ENQUEUED, '0, 1'b0, 1));
    rows.push_back(make_row(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b1, 1'b1, ST_ENQUEUED, '0, 1'b0, 2));
    rows.push_back(make_row(ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_ENQUEUED, '0, 1'b0, 3));
    rows.push_back(make_row(ACT_ENQUEUE, 32'h0000_0000, 1'b1, 1'b1, ST_ENQUEUED, '0, 1'b0, 4));
    rows.push_back(make_row(ACT_DEQUEUE, 32'h0000_0000, 1'b0, 1'b1, ST_DEQUEUED,
                            32'hFFFF_FFFF, 1'b1, 3));
    rows.push_back(make_row(ACT_DEQUEUE, 32'h0000_0000, 1'b0, 1'b1, ST_DEQUEUED,
                            32'h0000_0000, 1'b1, 2));
    rows.push_back(make_row(ACT_DEQUEUE, 32'h0000_0000, 1'b0, 1'b1, ST_DEQUEUED,
                            32'h0000_0000, 1'b0, 1));
    for (int i = 0; i < CAPACITY - 1; i++) begin
      rows.push_back(make_row(ACT_ENQUEUE, (i % 2) ? 32'h5A5A_0000 + i : 32'hA5A5_0000 + i,
                              i[0], 1'b0, ST_ENQUEUED, '0, 1'b0, 0));
    end
    rows.push_back(make_row(ACT_ENQUEUE, 32'h1234_5678, 1'b1, 1'b1, ST_FULL, '0, 1'b0,
                            CAPACITY));
    foreach (rows[i]) begin
      send_item(rows[i]);
    end

    // Enqueue-heavy, balanced and dequeue-heavy bursts drive the queue between full and empty.
    for (int n = 0; n < 600; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: begin
            enq_pct = 25;
          end
          1: begin
            enq_pct = 50;
          end
          default: begin
            enq_pct = 80;
          end
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      case ($urandom_range(0, 19))
        0: begin
          id = '0;
        end
        1: begin
          id = '1;
        end
        default: begin
          id = $urandom;
        end
      endcase
      row = make_row(($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE, id,
                     1'($urandom_range(0, 1)), 1'b0, ST_ENQUEUED, '0, 1'b0, 0);
      send_item(row);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    wait (awaited_results.size() == 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
